// ===== hw/rtl/lgt_pkg.sv =====
// Shared types and constants for the toroidal Life generation unit.
`timescale 1ns / 1ps
`default_nettype none

package lgt_pkg;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] col;
        logic [4:0] row;
        logic       cell_in;
    } t_in_item;

    typedef struct packed {
        logic cell_out;
        logic grid_changed;
    } t_out_item;

    typedef struct packed {
        logic latch_item;
        logic clr_res;
        logic clear_wr;
        logic rd_item;
        logic wr_item;
        logic cap_cell;
        logic rd_last;
        logic rd_first;
        logic rd_next;
        logic shift;
        logic adv_wr;
        logic row_clr;
        logic row_inc;
        logic swap;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_wr;
        logic is_rd;
        logic is_adv;
        logic in_range;
        logic row_last;
        logic out_free;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/lgt_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module lgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/lgt_ctrl.sv =====
// Sequencing state machine for clearing, cell access and generation steps.
`timescale 1ns / 1ps
`default_nettype none

module lgt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire lgt_pkg::t_ctrl_stat i_stat,
    output lgt_pkg::t_ctrl_cmd      o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_CRD   = 4'd3;
    localparam logic [3:0] S_CWR   = 4'd4;
    localparam logic [3:0] S_PA    = 4'd5;
    localparam logic [3:0] S_PB    = 4'd6;
    localparam logic [3:0] S_PC    = 4'd7;
    localparam logic [3:0] S_AR    = 4'd8;
    localparam logic [3:0] S_AC    = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.row_inc  = 1'b1;
                if (i_stat.row_last) begin
                    o_cmd.row_inc = 1'b0;
                    o_cmd.row_clr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.clr_res = 1'b1;
                if (i_stat.is_adv) begin
                    n_state = S_PA;
                end else if ((i_stat.is_wr || i_stat.is_rd) && i_stat.in_range) begin
                    n_state = S_CRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CRD: begin
                o_cmd.rd_item = 1'b1;
                n_state       = S_CWR;
            end
            S_CWR: begin
                o_cmd.wr_item  = i_stat.is_wr;
                o_cmd.cap_cell = i_stat.is_rd;
                n_state        = S_DONE;
            end
            S_PA: begin
                o_cmd.rd_last = 1'b1;
                n_state       = S_PB;
            end
            S_PB: begin
                o_cmd.shift    = 1'b1;
                o_cmd.rd_first = 1'b1;
                n_state        = S_PC;
            end
            S_PC: begin
                o_cmd.shift   = 1'b1;
                o_cmd.row_clr = 1'b1;
                n_state       = S_AR;
            end
            S_AR: begin
                o_cmd.rd_next = 1'b1;
                n_state       = S_AC;
            end
            S_AC: begin
                o_cmd.adv_wr  = 1'b1;
                o_cmd.shift   = 1'b1;
                o_cmd.row_inc = 1'b1;
                n_state       = S_AR;
                if (i_stat.row_last) begin
                    o_cmd.row_inc = 1'b0;
                    o_cmd.row_clr = 1'b1;
                    o_cmd.swap    = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/lgt_dpath.sv =====
// Grid stores, row window, neighbor counting lanes and result register.
`timescale 1ns / 1ps
`default_nettype none

module lgt_dpath #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lgt_pkg::t_in_item    i_in_data,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output lgt_pkg::t_out_item        o_out_data,
    input  wire lgt_pkg::t_ctrl_cmd   i_cmd,
    output lgt_pkg::t_ctrl_stat       o_stat
);

    localparam int RA_W = $clog2(GRID_HEIGHT);
    localparam int CA_W = $clog2(GRID_WIDTH);
    localparam logic [RA_W-1:0] ROW_LAST = RA_W'(GRID_HEIGHT - 1);

    lgt_pkg::t_in_item  r_item;
    lgt_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic               r_sel;
    logic [RA_W-1:0]    r_row;
    logic               r_changed;
    logic               r_res_cell;
    logic [GRID_WIDTH-1:0] r_top;
    logic [GRID_WIDTH-1:0] r_mid;

    logic [RA_W-1:0]       item_row;
    logic [CA_W-1:0]       item_col;
    logic [RA_W-1:0]       raddr;
    logic [RA_W-1:0]       waddr;
    logic                  re;
    logic                  we0;
    logic                  we1;
    logic [GRID_WIDTH-1:0] wdata;
    logic [GRID_WIDTH-1:0] rdata0;
    logic [GRID_WIDTH-1:0] rdata1;
    logic [GRID_WIDTH-1:0] rdata;
    logic [GRID_WIDTH-1:0] patched;
    logic [GRID_WIDTH-1:0] next_row;

    assign item_row = RA_W'(r_item.row);
    assign item_col = CA_W'(r_item.col);
    assign rdata    = r_sel ? rdata1 : rdata0;

    always_comb begin
        patched           = rdata;
        patched[item_col] = r_item.cell_in;
    end

    always_comb begin
        raddr = item_row;
        if (i_cmd.rd_last) begin
            raddr = ROW_LAST;
        end else if (i_cmd.rd_first) begin
            raddr = '0;
        end else if (i_cmd.rd_next) begin
            raddr = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
        end
    end

    assign re = i_cmd.rd_item || i_cmd.rd_last || i_cmd.rd_first || i_cmd.rd_next;

    always_comb begin
        waddr = r_row;
        wdata = '0;
        if (i_cmd.wr_item) begin
            waddr = item_row;
            wdata = patched;
        end else if (i_cmd.adv_wr) begin
            wdata = next_row;
        end
    end

    assign we0 = i_cmd.clear_wr || (i_cmd.wr_item && !r_sel) || (i_cmd.adv_wr && r_sel);
    assign we1 = i_cmd.clear_wr || (i_cmd.wr_item && r_sel) || (i_cmd.adv_wr && !r_sel);

    lgt_ram #(
        .WIDTH(GRID_WIDTH),
        .DEPTH(GRID_HEIGHT)
    ) u_grid_zero (
        .i_clk  (i_clk),
        .i_we   (we0),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata0)
    );

    lgt_ram #(
        .WIDTH(GRID_WIDTH),
        .DEPTH(GRID_HEIGHT)
    ) u_grid_one (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata1)
    );

    // One lane per column; the row below comes straight from the store.
    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_cell
        localparam int CL = (c == 0) ? GRID_WIDTH - 1 : c - 1;
        localparam int CR = (c == GRID_WIDTH - 1) ? 0 : c + 1;
        logic [3:0] nb;
        assign nb = 4'(r_top[CL]) + 4'(r_top[c]) + 4'(r_top[CR])
                  + 4'(r_mid[CL]) + 4'(r_mid[CR])
                  + 4'(rdata[CL]) + 4'(rdata[c]) + 4'(rdata[CR]);
        assign next_row[c] = r_mid[c]
            ? (nb >= lgt_pkg::SURVIVE_LOW && nb <= lgt_pkg::SURVIVE_HIGH)
            : (nb == lgt_pkg::BIRTH_COUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.swap) begin
                r_sel <= ~r_sel;
            end
            if (i_cmd.row_clr) begin
                r_row <= '0;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.clr_res) begin
            r_changed  <= 1'b0;
            r_res_cell <= 1'b0;
        end else begin
            if (i_cmd.cap_cell) begin
                r_res_cell <= rdata[item_col];
            end
            if (i_cmd.adv_wr) begin
                r_changed <= r_changed | (|(next_row ^ r_mid));
            end
        end
        if (i_cmd.shift) begin
            r_top <= r_mid;
            r_mid <= rdata;
        end
        if (i_cmd.load_out) begin
            r_out.cell_out     <= r_res_cell;
            r_out.grid_changed <= r_changed;
        end
    end

    assign o_stat.is_wr    = (r_item.cmd == lgt_pkg::CMD_WRITE);
    assign o_stat.is_rd    = (r_item.cmd == lgt_pkg::CMD_READ);
    assign o_stat.is_adv   = (r_item.cmd == lgt_pkg::CMD_ADVANCE);
    assign o_stat.in_range = (32'(r_item.col) < GRID_WIDTH) && (32'(r_item.row) < GRID_HEIGHT);
    assign o_stat.row_last = (r_row == ROW_LAST);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/life_generation_toroidal_unit.sv =====
// Top level of the toroidal Life generation unit.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//
// A write or read item passes through decode, a store read and then a write
// or a capture before its result is loaded. An advance item reads the last
// and first rows, then reads each grid row and writes its next generation to
// the other store in turn. All columns of a row are evaluated in parallel.
// After reset both stores are cleared one row per cycle while the input is
// stalled. A stalled result holds its register, and a new item is accepted while it waits.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_toroidal_unit #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire lgt_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output lgt_pkg::t_out_item      o_out_data
);

    lgt_pkg::t_ctrl_cmd  cmd;
    lgt_pkg::t_ctrl_stat stat;

    lgt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lgt_dpath #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input accepted while an item was in progress.");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_wr, cmd.wr_item, cmd.adv_wr}))
        else $error("Conflicting store writes in one cycle.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("Result register overwritten while stalled.");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input not stalled during the clearing pass.");
`endif

endmodule

`default_nettype wire

// ===== test/tb_life_generation_toroidal_unit.sv =====
// Self-checking testbench for the toroidal Life generation unit, with directed and random items.
`timescale 1ns / 1ps

module tb_life_generation_toroidal_unit;

    localparam int GRID_W = 64;
    localparam int GRID_H = 32;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM = 265;
    localparam int TAIL_CYCLES = 2 * GRID_H + 10;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        lgt_pkg::t_in_item  item;
        logic               known;
        lgt_pkg::t_out_item want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    lgt_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    lgt_pkg::t_out_item o_out_data;

    bit [GRID_W-1:0]    life_cells [GRID_H];
    lgt_pkg::t_out_item pending_q [$];
    t_stim_row          dir_tab [N_DIRECTED];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    bit                 quiet_in = 1'b0;
    bit                 quiet_out = 1'b0;

    life_generation_toroidal_unit #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Applies one item to the grid copy and returns the result it should produce.
    function automatic lgt_pkg::t_out_item life_predict(lgt_pkg::t_in_item it);
        lgt_pkg::t_out_item res;
        bit [GRID_W-1:0]    next_gen [GRID_H];
        int                 up, dn, lf, rt, n;
        res = '0;
        case (it.cmd)
            lgt_pkg::CMD_WRITE: begin
                if (it.col < GRID_W && it.row < GRID_H)
                    life_cells[it.row][it.col] = it.cell_in;
            end
            lgt_pkg::CMD_READ: begin
                if (it.col < GRID_W && it.row < GRID_H)
                    res.cell_out = life_cells[it.row][it.col];
            end
            lgt_pkg::CMD_ADVANCE: begin
                for (int r = 0; r < GRID_H; r++) begin
                    up = (r + GRID_H - 1) % GRID_H;
                    dn = (r + 1) % GRID_H;
                    for (int c = 0; c < GRID_W; c++) begin
                        lf = (c + GRID_W - 1) % GRID_W;
                        rt = (c + 1) % GRID_W;
                        n = life_cells[up][lf] + life_cells[up][c] + life_cells[up][rt]
                          + life_cells[r][lf] + life_cells[r][rt]
                          + life_cells[dn][lf] + life_cells[dn][c] + life_cells[dn][rt];
                        if (life_cells[r][c])
                            next_gen[r][c] = (n >= lgt_pkg::SURVIVE_LOW
                                              && n <= lgt_pkg::SURVIVE_HIGH);
                        else
                            next_gen[r][c] = (n == lgt_pkg::BIRTH_COUNT);
                        if (next_gen[r][c] != life_cells[r][c])
                            res.grid_changed = 1'b1;
                    end
                end
                life_cells = next_gen;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_stim_row mk_row(logic [1:0] cmd, int col, int row, logic cell_val,
                                         logic known, logic cell_out, logic changed);
        t_stim_row s;
        s.item.cmd = cmd;
        s.item.col = 6'(col);
        s.item.row = 5'(row);
        s.item.cell_in = cell_val;
        s.known = known;
        s.want.cell_out = cell_out;
        s.want.grid_changed = changed;
        return s;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else if (p < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 100);
    endfunction

    task automatic push_item(lgt_pkg::t_in_item it, logic known, lgt_pkg::t_out_item want);
        bit                 go;
        lgt_pkg::t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        go = 1'b0;
        while (!go) begin
            @(negedge i_clk);
            go = !o_in_stall;
            @(posedge i_clk);
        end
        predicted = life_predict(it);
        pending_q.push_back(known ? want : predicted);
    endtask

    task automatic idle_sender(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic flag_mismatch(string what, lgt_pkg::t_out_item want,
                                 lgt_pkg::t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected cell_out=%0b grid_changed=%0b, got %0b %0b",
                     $realtime, what, want.cell_out, want.grid_changed,
                     got.cell_out, got.grid_changed);
    endtask

    always @(posedge i_clk) begin : out_stall_gen
        int n;
        if ($urandom_range(0, 199) == 0)
            quiet_out <= ~quiet_out;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            n = quiet_out ? 0 : pick_gap();
            i_out_stall <= (n != 0);
            stall_left <= (n != 0) ? n - 1 : 0;
        end
    end

    always @(negedge i_clk) begin : result_check
        lgt_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                flag_mismatch("unexpected result", '0, o_out_data);
            end else begin
                want = pending_q.pop_front();
                if (o_out_data.cell_out !== want.cell_out
                    || o_out_data.grid_changed !== want.grid_changed)
                    flag_mismatch("result mismatch", want, o_out_data);
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        lgt_pkg::t_in_item it;
        bit [5:0]          win_col;
        bit [4:0]          win_row;
        int                p;
        for (int r = 0; r < GRID_H; r++)
            life_cells[r] = '0;

        // The two corner cells are diagonal neighbors across both wrap edges.
        dir_tab[0]  = mk_row(lgt_pkg::CMD_READ,     0,  0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab[1]  = mk_row(lgt_pkg::CMD_READ,    63, 31, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab[2]  = mk_row(lgt_pkg::CMD_ADVANCE,  0,  0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab[3]  = mk_row(CMD_UNUSED,           63, 31, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[4]  = mk_row(lgt_pkg::CMD_WRITE,    0,  0, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[5]  = mk_row(lgt_pkg::CMD_WRITE,   63, 31, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[6]  = mk_row(lgt_pkg::CMD_READ,     0,  0, 1'b0, 1'b1, 1'b1, 1'b0);
        dir_tab[7]  = mk_row(lgt_pkg::CMD_READ,    63, 31, 1'b0, 1'b1, 1'b1, 1'b0);
        dir_tab[8]  = mk_row(lgt_pkg::CMD_ADVANCE,  0,  0, 1'b0, 1'b0, 1'b0, 1'b0);
        // A blinker that straddles the column wrap and flips across the row wrap.
        dir_tab[9]  = mk_row(lgt_pkg::CMD_WRITE,   63,  0, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[10] = mk_row(lgt_pkg::CMD_WRITE,    0,  0, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[11] = mk_row(lgt_pkg::CMD_WRITE,    1,  0, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[12] = mk_row(lgt_pkg::CMD_ADVANCE,  0,  0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab[13] = mk_row(lgt_pkg::CMD_READ,     0, 31, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab[14] = mk_row(lgt_pkg::CMD_READ,     0,  1, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab[15] = mk_row(lgt_pkg::CMD_ADVANCE,  0,  0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab[16] = mk_row(lgt_pkg::CMD_READ,    63,  0, 1'b0, 1'b0, 1'b0, 1'b0);
        dir_tab[17] = mk_row(lgt_pkg::CMD_WRITE,   63,  0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab[18] = mk_row(lgt_pkg::CMD_WRITE,    0,  0, 1'b0, 1'b1, 1'b0, 1'b0);
        dir_tab[19] = mk_row(lgt_pkg::CMD_WRITE,    1,  0, 1'b0, 1'b1, 1'b0, 1'b0);
        // A block is a still life, so the advance reports no change.
        dir_tab[20] = mk_row(lgt_pkg::CMD_WRITE,   30, 15, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[21] = mk_row(lgt_pkg::CMD_WRITE,   31, 15, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[22] = mk_row(lgt_pkg::CMD_WRITE,   30, 16, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[23] = mk_row(lgt_pkg::CMD_WRITE,   31, 16, 1'b1, 1'b1, 1'b0, 1'b0);
        dir_tab[24] = mk_row(lgt_pkg::CMD_ADVANCE,  0,  0, 1'b0, 1'b0, 1'b0, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            push_item(dir_tab[k].item, dir_tab[k].known, dir_tab[k].want);
            idle_sender(pick_gap());
        end
        drain_results();

        win_col = 6'($urandom_range(0, 63));
        win_row = 5'($urandom_range(0, 31));
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 30 == 29) begin
                win_col = 6'($urandom_range(0, 63));
                win_row = 5'($urandom_range(0, 31));
            end
            it.col = win_col + 6'($urandom_range(0, 7));
            it.row = win_row + 5'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 2) begin
                it.col = 6'($urandom_range(0, 63));
                it.row = 5'($urandom_range(0, 31));
            end
            it.cell_in = ($urandom_range(0, 99) < 60);
            p = $urandom_range(0, 99);
            if (p < 55)
                it.cmd = lgt_pkg::CMD_WRITE;
            else if (p < 80)
                it.cmd = lgt_pkg::CMD_READ;
            else if (p < 95)
                it.cmd = lgt_pkg::CMD_ADVANCE;
            else
                it.cmd = CMD_UNUSED;
            push_item(it, 1'b0, '0);
            if ($urandom_range(0, 39) == 0)
                quiet_in = ~quiet_in;
            if ($urandom_range(0, 49) == 0)
                drain_results();
            else
                idle_sender(quiet_in ? 0 : pick_gap());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== life_generation_toroidal_unit.f =====
hw/rtl/lgt_pkg.sv
hw/rtl/lgt_ram.sv
hw/rtl/lgt_ctrl.sv
hw/rtl/lgt_dpath.sv
hw/rtl/life_generation_toroidal_unit.sv
test/tb_life_generation_toroidal_unit.sv
